/* sv/hdp_pkg.sv */
// shared types, constants and name tables for the http date parser
`timescale 1ns / 1ps

package hdp_pkg;

  // field being parsed, in header order
  typedef enum logic [2:0] {
    FLD_WDAY  = 3'd0,
    FLD_DAY   = 3'd1,
    FLD_MONTH = 3'd2,
    FLD_YEAR  = 3'd3,
    FLD_HOUR  = 3'd4,
    FLD_MIN   = 3'd5,
    FLD_SEC   = 3'd6,
    FLD_ZONE  = 3'd7
  } field_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_WDAY  = 2'd1,
    ST_BAD_MONTH = 2'd2,
    ST_MALFORMED = 2'd3
  } status_e;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } date_t;

  // parsed header, handed from the parser to the shift stage
  typedef struct packed {
    date_t   date;
    logic    leap;
    status_e status;
  } parse_res_t;

  localparam int unsigned MatchLen = 3;

  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [13:0] YearMax       = 14'd9999;
  localparam logic [13:0] AccumSatLimit = 14'd1000;
  localparam logic [4:0]  DayMax        = 5'd31;
  localparam logic [4:0]  HourMax       = 5'd23;
  localparam logic [5:0]  MinuteMax     = 6'd59;
  localparam logic [5:0]  SecondMax     = 6'd60;
  localparam logic [3:0]  MonthsPerYear = 4'd12;
  localparam logic [3:0]  MonthNone     = 4'd0;
  localparam logic [2:0]  DaysPerWeek   = 3'd7;
  localparam logic [2:0]  WdayNone      = 3'd0;
  localparam logic [5:0]  HoursPerDay   = 6'd24;
  localparam logic [4:0]  OffsetMax     = 5'd23;
  localparam logic [4:0]  OffsetReset   = 5'd8;
  localparam logic [2:0]  LenMax        = 3'd7;

  // 1=Mon .. 7=Sun, 0 when unknown
  function automatic logic [2:0] wday_lookup(input logic [23:0] s);
    logic [2:0] r;
    unique case (s)
      "Mon":   r = 3'd1;
      "Tue":   r = 3'd2;
      "Wed":   r = 3'd3;
      "Thu":   r = 3'd4;
      "Fri":   r = 3'd5;
      "Sat":   r = 3'd6;
      "Sun":   r = 3'd7;
      default: r = WdayNone;
    endcase
    return r;
  endfunction

  // 1=Jan .. 12=Dec, 0 when unknown
  function automatic logic [3:0] month_lookup(input logic [23:0] s);
    logic [3:0] r;
    unique case (s)
      "Jan":   r = 4'd1;
      "Feb":   r = 4'd2;
      "Mar":   r = 4'd3;
      "Apr":   r = 4'd4;
      "May":   r = 4'd5;
      "Jun":   r = 4'd6;
      "Jul":   r = 4'd7;
      "Aug":   r = 4'd8;
      "Sep":   r = 4'd9;
      "Oct":   r = 4'd10;
      "Nov":   r = 4'd11;
      "Dec":   r = 4'd12;
      default: r = MonthNone;
    endcase
    return r;
  endfunction

  // unknown month counts as 31 days
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m) inside
      4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd2:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd30;
    endcase
    return r;
  endfunction

endpackage

/* sv/hdp_parser.sv */
// character parser: field tracking, name match, decimal build, result capture
`timescale 1ns / 1ps

module hdp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          char_in_i,
  input  logic                end_of_text_i,
  output logic                in_stall_o,
  output logic                res_valid_o,
  output hdp_pkg::parse_res_t res_o,
  input  logic                res_ready_i
);

  hdp_pkg::field_e  field_q, field_d, field1;
  logic [13:0]      acc_q, acc_d, acc1;
  logic [3:0][3:0]  bcd_q, bcd_d, bcd1;
  logic [2:0]       len_q, len_d, len1;
  logic [hdp_pkg::MatchLen-1:0][7:0] name_q, name_d;
  logic [23:0]      name_str;
  hdp_pkg::date_t   fields_q, fields_d, fields1;
  logic             leap_q, leap_d, leap1;
  hdp_pkg::status_e err_q, err_d, err1, err_new;
  hdp_pkg::parse_res_t res_q, res_d, fin;
  logic             res_valid_q, res_valid_d;

  logic       accept, is_digit, is_num, is_hm, num_commit, stray, final_commit;
  logic [7:0] sep;
  logic [3:0] digit;
  logic       cent;
  logic [1:0] hi_mod4;

  assign in_stall_o = res_valid_q && !res_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  // first character in the top byte, as in a string literal
  assign name_str   = {name_q[0], name_q[1], name_q[2]};

  assign is_digit   = (char_in_i >= hdp_pkg::CharZero) && (char_in_i <= hdp_pkg::CharNine);
  assign digit      = char_in_i[3:0];
  assign is_hm      = (field_q == hdp_pkg::FLD_HOUR) || (field_q == hdp_pkg::FLD_MIN);
  assign is_num     = (field_q == hdp_pkg::FLD_DAY) || (field_q == hdp_pkg::FLD_YEAR) ||
                      is_hm || (field_q == hdp_pkg::FLD_SEC);
  assign sep        = is_hm ? hdp_pkg::CharColon : hdp_pkg::CharSpace;
  assign num_commit = is_num && (char_in_i == sep) && (is_hm || (len_q != 3'd0));
  assign stray      = is_num && !is_digit && (char_in_i != sep);

  // year leap test from the decimal digits: century years need hundreds divisible by 4
  assign cent    = (bcd_q[1] == 4'd0) && (bcd_q[0] == 4'd0);
  assign hi_mod4 = bcd_q[2][1:0] + {bcd_q[3][0], 1'b0};

  // next field
  always_comb begin
    field1 = field_q;
    unique case (field_q)
      hdp_pkg::FLD_WDAY: begin
        if (char_in_i == hdp_pkg::CharComma) field1 = hdp_pkg::FLD_DAY;
      end
      hdp_pkg::FLD_MONTH: begin
        if (char_in_i == hdp_pkg::CharSpace && len_q != 3'd0) field1 = hdp_pkg::FLD_YEAR;
      end
      hdp_pkg::FLD_ZONE: begin
        field1 = field_q;
      end
      default: begin
        if (num_commit) field1 = hdp_pkg::field_e'(field_q + 3'd1);
      end
    endcase
    if (!accept) field_d = field_q;
    else if (end_of_text_i) field_d = hdp_pkg::FLD_WDAY;
    else field_d = field1;
  end

  // datapath for one character
  always_comb begin
    acc1    = acc_q;
    bcd1    = bcd_q;
    len1    = len_q;
    name_d  = name_q;
    fields1 = fields_q;
    leap1   = leap_q;
    err_new = hdp_pkg::ST_OK;
    unique case (field_q) inside
      hdp_pkg::FLD_WDAY, hdp_pkg::FLD_MONTH: begin
        if (field_q == hdp_pkg::FLD_WDAY && char_in_i == hdp_pkg::CharComma) begin
          fields1.weekday = (len_q == 3'd3) ? hdp_pkg::wday_lookup(name_str) : hdp_pkg::WdayNone;
          if (fields1.weekday == hdp_pkg::WdayNone) err_new = hdp_pkg::ST_BAD_WDAY;
          len1 = 3'd0;
        end else if (field_q == hdp_pkg::FLD_MONTH && char_in_i == hdp_pkg::CharSpace) begin
          if (len_q != 3'd0) begin
            fields1.month = (len_q == 3'd3) ? hdp_pkg::month_lookup(name_str)
                                            : hdp_pkg::MonthNone;
            if (fields1.month == hdp_pkg::MonthNone) err_new = hdp_pkg::ST_BAD_MONTH;
            len1 = 3'd0;
          end
        end else begin
          if (len_q < 3'(hdp_pkg::MatchLen)) name_d[len_q[1:0]] = char_in_i;
          if (len_q < hdp_pkg::LenMax) len1 = len_q + 3'd1;
        end
      end
      hdp_pkg::FLD_ZONE: begin
        len1 = len_q;
      end
      default: begin
        if (is_digit) begin
          // saturate once the value has four digits
          if (acc_q >= hdp_pkg::AccumSatLimit) begin
            acc1 = hdp_pkg::YearMax;
            bcd1 = {4'd9, 4'd9, 4'd9, 4'd9};
          end else begin
            acc1 = (acc_q << 3) + (acc_q << 1) + {10'd0, digit};
            bcd1 = {bcd_q[2], bcd_q[1], bcd_q[0], digit};
          end
          if (len_q < hdp_pkg::LenMax) len1 = len_q + 3'd1;
        end else if (num_commit) begin
          if (len_q == 3'd0) err_new = hdp_pkg::ST_MALFORMED;
          case (field_q)
            hdp_pkg::FLD_DAY:
              fields1.day = (acc_q > 14'(hdp_pkg::DayMax)) ? hdp_pkg::DayMax : acc_q[4:0];
            hdp_pkg::FLD_YEAR: begin
              fields1.year = acc_q;
              leap1 = (acc_q[1:0] == 2'd0) && (!cent || (hi_mod4 == 2'd0));
            end
            hdp_pkg::FLD_HOUR:
              fields1.hour = (acc_q > 14'(hdp_pkg::HourMax)) ? hdp_pkg::HourMax : acc_q[4:0];
            hdp_pkg::FLD_MIN:
              fields1.minute = (acc_q > 14'(hdp_pkg::MinuteMax)) ? hdp_pkg::MinuteMax
                                                                 : acc_q[5:0];
            default:
              fields1.second = (acc_q > 14'(hdp_pkg::SecondMax)) ? hdp_pkg::SecondMax
                                                                 : acc_q[5:0];
          endcase
          acc1 = 14'd0;
          bcd1 = '0;
          len1 = 3'd0;
        end else if (stray) begin
          err_new = hdp_pkg::ST_MALFORMED;
        end
      end
    endcase
    err1 = (err_q != hdp_pkg::ST_OK) ? err_q : err_new;

    // end of text: seconds still open are committed, anything else unfinished is malformed
    final_commit = (field1 == hdp_pkg::FLD_SEC) && (len1 != 3'd0);
    fin.date     = fields1;
    fin.leap     = leap1;
    fin.status   = err1;
    if (final_commit) begin
      fin.date.second = (acc1 > 14'(hdp_pkg::SecondMax)) ? hdp_pkg::SecondMax : acc1[5:0];
    end else if (field1 != hdp_pkg::FLD_ZONE && err1 == hdp_pkg::ST_OK) begin
      fin.status = hdp_pkg::ST_MALFORMED;
    end

    acc_d    = acc_q;
    bcd_d    = bcd_q;
    len_d    = len_q;
    fields_d = fields_q;
    leap_d   = leap_q;
    err_d    = err_q;
    if (accept) begin
      if (end_of_text_i) begin
        acc_d    = 14'd0;
        bcd_d    = '0;
        len_d    = 3'd0;
        fields_d = '0;
        leap_d   = 1'b1;
        err_d    = hdp_pkg::ST_OK;
      end else begin
        acc_d    = acc1;
        bcd_d    = bcd1;
        len_d    = len1;
        fields_d = fields1;
        leap_d   = leap1;
        err_d    = err1;
      end
    end

    res_d       = (accept && end_of_text_i) ? fin : res_q;
    res_valid_d = (accept && end_of_text_i) ? 1'b1 : (res_ready_i ? 1'b0 : res_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q     <= hdp_pkg::FLD_WDAY;
      acc_q       <= 14'd0;
      bcd_q       <= '0;
      len_q       <= 3'd0;
      fields_q    <= '0;
      leap_q      <= 1'b1;
      err_q       <= hdp_pkg::ST_OK;
      res_valid_q <= 1'b0;
    end else begin
      field_q     <= field_d;
      acc_q       <= acc_d;
      bcd_q       <= bcd_d;
      len_q       <= len_d;
      fields_q    <= fields_d;
      leap_q      <= leap_d;
      err_q       <= err_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    name_q <= name_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* sv/hdp_shift.sv */
// hour offset and calendar rollover into the output register
`timescale 1ns / 1ps

module hdp_shift (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  hdp_pkg::parse_res_t res_i,
  output logic                res_ready_o,
  input  logic [4:0]          offset_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hdp_pkg::date_t      date_o,
  output hdp_pkg::status_e    status_o
);

  hdp_pkg::date_t   d, date_q;
  hdp_pkg::status_e status_q;
  logic             out_valid_q, out_valid_d, load;
  logic [4:0]       off, dim;
  logic [5:0]       hsum, day1;

  assign res_ready_o = !out_valid_q || !out_stall_i;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    d    = res_i.date;
    off  = (offset_i > hdp_pkg::OffsetMax) ? hdp_pkg::OffsetMax : offset_i;
    hsum = {1'b0, res_i.date.hour} + {1'b0, off};
    day1 = {1'b0, res_i.date.day} + 6'd1;
    dim  = hdp_pkg::days_in_month(res_i.date.month, res_i.leap);
    if (hsum >= hdp_pkg::HoursPerDay) begin
      d.hour = 5'(hsum - hdp_pkg::HoursPerDay);
      if (res_i.date.weekday != hdp_pkg::WdayNone) begin
        d.weekday = (res_i.date.weekday == hdp_pkg::DaysPerWeek) ? 3'd1
                                                                 : res_i.date.weekday + 3'd1;
      end
      if (day1 > {1'b0, dim}) begin
        d.day = 5'(day1 - {1'b0, dim});
        if (res_i.date.month != hdp_pkg::MonthNone) begin
          if (res_i.date.month == hdp_pkg::MonthsPerYear) begin
            d.month = 4'd1;
            if (res_i.date.year < hdp_pkg::YearMax) d.year = res_i.date.year + 14'd1;
          end else begin
            d.month = res_i.date.month + 4'd1;
          end
        end
      end else begin
        d.day = day1[4:0];
      end
    end else begin
      d.hour = hsum[4:0];
    end
    out_valid_d = load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      date_q   <= d;
      status_q <= res_i.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign date_o      = date_q;
  assign status_o    = status_q;

endmodule

/* sv/http_date_parse_tz_shift.sv */
// http date header parser with local hour offset: top level
// one character transfer per cycle while in_stall_o is low; the parser state updates in the same cycle
// a result from the transfer that carries end_of_text is held first in the parser's capture register,
//   then passes through the offset and rollover logic into the output register
// rst_ni clears the parser, both valid flags and sets offset_hours to 8
`timescale 1ns / 1ps

module http_date_parse_tz_shift (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        offset_hours_we_i,
  input  logic [4:0]  offset_hours_i,
  // character channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  input  logic        end_of_text_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [13:0] year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o,
  output logic [2:0]  weekday_out_o,
  output logic [1:0]  status_o
);

  // offset register; the user must write it only while the block is idle, the block does not enforce it
  logic [4:0] offset_q, offset_d;

  hdp_pkg::parse_res_t res;
  logic                res_valid, res_ready;
  hdp_pkg::date_t      date;
  hdp_pkg::status_e    status;

  assign offset_d = offset_hours_we_i ? offset_hours_i : offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= hdp_pkg::OffsetReset;
    end else begin
      offset_q <= offset_d;
    end
  end

  // per-character parsing; captures the finished date on end_of_text
  hdp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .char_in_i     (char_in_i),
    .end_of_text_i (end_of_text_i),
    .in_stall_o    (in_stall_o),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (res_ready)
  );

  // time zone shift with day, weekday, month and year rollover
  hdp_shift u_shift (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .offset_i    (offset_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .date_o      (date),
    .status_o    (status)
  );

  assign year_out_o    = date.year;
  assign month_out_o   = date.month;
  assign day_out_o     = date.day;
  assign hour_out_o    = date.hour;
  assign minute_out_o  = date.minute;
  assign second_out_o  = date.second;
  assign weekday_out_o = date.weekday;
  assign status_o      = status;

endmodule

/* bench/tb_http_date_parse_tz_shift.sv */
// self-checking testbench for the http date parser with local hour offset
`timescale 1ns / 1ps

module tb_http_date_parse_tz_shift;
  import hdp_pkg::*;

  localparam int unsigned QuietLimit  = 4000; // cycles without any transfer
  localparam int unsigned HoldCycles  = 300;  // long receiver hold-off
  localparam int unsigned DrainCycles = 8;    // covers the two-stage result latency
  localparam int unsigned PhaseChars  = 130;  // characters per random phase
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned NameChars   = 4;

  // expected result: local date plus status
  typedef struct packed {
    date_t   d;
    status_e st;
  } shifted_date_t;

  typedef struct {
    string         text;
    bit            typed;
    shifted_date_t want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni            = 1'b0;
  logic        offset_hours_we_i = 1'b0;
  logic [4:0]  offset_hours_i    = '0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_in_i         = '0;
  logic        end_of_text_i     = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [13:0] year_out_o;
  logic [3:0]  month_out_o;
  logic [4:0]  day_out_o;
  logic [4:0]  hour_out_o;
  logic [5:0]  minute_out_o;
  logic [5:0]  second_out_o;
  logic [2:0]  weekday_out_o;
  logic [1:0]  status_o;

  http_date_parse_tz_shift uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .offset_hours_we_i(offset_hours_we_i),
    .offset_hours_i   (offset_hours_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .char_in_i        (char_in_i),
    .end_of_text_i    (end_of_text_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .year_out_o       (year_out_o),
    .month_out_o      (month_out_o),
    .day_out_o        (day_out_o),
    .hour_out_o       (hour_out_o),
    .minute_out_o     (minute_out_o),
    .second_out_o     (second_out_o),
    .weekday_out_o    (weekday_out_o),
    .status_o         (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  string wday_tab[7]   = '{"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun"};
  string month_tab[12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                           "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};

  // predictor state: parser position, partial number, name buffer, committed fields
  field_e        cur_field;
  int unsigned   digit_sum;
  byte unsigned  name_buf[NameChars];
  int unsigned   name_cnt;
  date_t         got_date;
  status_e       first_err;
  int unsigned   tz_offset;

  shifted_date_t shifted_q[$];   // local dates still owed by the block
  byte unsigned  text_q[$];      // header value being sent
  dir_row_t      dir_rows[$];
  int unsigned   err_count   = 0;
  int unsigned   sent_chars  = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct   = 0;
  int unsigned   quiet_cycles = 0;
  bit            holdoff_go  = 1'b0;
  logic          holdoff     = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic void note_err(status_e s);
    if (first_err == ST_OK) first_err = s;
  endfunction

  function automatic void reset_parser();
    cur_field = FLD_WDAY;
    digit_sum = 0;
    foreach (name_buf[i]) name_buf[i] = 8'h00;
    name_cnt  = 0;
    got_date  = '0;
    first_err = ST_OK;
  endfunction

  function automatic int unsigned month_days(int unsigned yr, int unsigned mo);
    bit leap;
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    case (mo)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // 1-based position in the weekday or month table, 0 when unknown
  function automatic int unsigned name_lookup(bit is_month);
    string s;
    if (name_cnt != MatchLen) return 0;
    for (int i = 0; i < (is_month ? 12 : 7); i++) begin
      s = is_month ? month_tab[i] : wday_tab[i];
      if (name_buf[0] == s[0] && name_buf[1] == s[1] && name_buf[2] == s[2]) return i + 1;
    end
    return 0;
  endfunction

  function automatic void keep_name_char(byte unsigned c);
    if (name_cnt < NameChars) name_buf[name_cnt] = c;
    if (name_cnt < LenMax) name_cnt++;
  endfunction

  function automatic void store_number();
    if (name_cnt == 0) note_err(ST_MALFORMED);
    case (cur_field)
      FLD_DAY:  got_date.day    = 5'(digit_sum > DayMax ? DayMax : digit_sum);
      FLD_YEAR: got_date.year   = 14'(digit_sum > YearMax ? YearMax : digit_sum);
      FLD_HOUR: got_date.hour   = 5'(digit_sum > HourMax ? HourMax : digit_sum);
      FLD_MIN:  got_date.minute = 6'(digit_sum > MinuteMax ? MinuteMax : digit_sum);
      default:  got_date.second = 6'(digit_sum > SecondMax ? SecondMax : digit_sum);
    endcase
    digit_sum = 0;
    name_cnt  = 0;
    cur_field = field_e'(cur_field + 1);
  endfunction

  function automatic void parse_char(byte unsigned c);
    logic [7:0] sep;
    case (cur_field)
      FLD_WDAY: begin
        if (c == CharComma) begin
          got_date.weekday = 3'(name_lookup(1'b0));
          if (got_date.weekday == WdayNone) note_err(ST_BAD_WDAY);
          name_cnt  = 0;
          cur_field = FLD_DAY;
        end else begin
          keep_name_char(c);
        end
      end
      FLD_MONTH: begin
        if (c == CharSpace) begin
          if (name_cnt != 0) begin
            got_date.month = 4'(name_lookup(1'b1));
            if (got_date.month == MonthNone) note_err(ST_BAD_MONTH);
            name_cnt  = 0;
            cur_field = FLD_YEAR;
          end
        end else begin
          keep_name_char(c);
        end
      end
      FLD_ZONE: ; // zone text ignored
      default: begin
        sep = (cur_field == FLD_HOUR || cur_field == FLD_MIN) ? CharColon : CharSpace;
        if (c >= CharZero && c <= CharNine) begin
          digit_sum = digit_sum * 10 + (c - CharZero);
          if (digit_sum > YearMax) digit_sum = YearMax;
          if (name_cnt < LenMax) name_cnt++;
        end else if (c == CharSpace && name_cnt == 0 && sep == CharSpace) begin
          // leading space before the number
        end else if (c == sep) begin
          store_number();
        end else begin
          note_err(ST_MALFORMED);
        end
      end
    endcase
  endfunction

  // end of text: close the second field, shift by the offset, roll the date over
  function automatic shifted_date_t close_header();
    shifted_date_t r;
    int unsigned   hr, dy, mo, yr, wd;
    if (cur_field == FLD_SEC && name_cnt != 0) store_number();
    else if (cur_field != FLD_ZONE) note_err(ST_MALFORMED);
    hr = got_date.hour + (tz_offset > OffsetMax ? OffsetMax : tz_offset);
    dy = got_date.day;
    mo = got_date.month;
    yr = got_date.year;
    wd = got_date.weekday;
    if (hr >= HoursPerDay) begin
      hr -= HoursPerDay;
      if (wd != 0) wd = wd % DaysPerWeek + 1;
      dy++;
      if (mo == 0) begin
        if (dy > DayMax) dy = 1;
      end else if (dy > month_days(yr, mo)) begin
        dy -= month_days(yr, mo);
        mo++;
        if (mo > MonthsPerYear) begin
          mo = 1;
          if (yr < YearMax) yr++;
        end
      end
    end
    r.d.year    = 14'(yr);
    r.d.month   = 4'(mo);
    r.d.day     = 5'(dy);
    r.d.hour    = 5'(hr);
    r.d.minute  = got_date.minute;
    r.d.second  = got_date.second;
    r.d.weekday = 3'(wd);
    r.st        = first_err;
    reset_parser();
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_row(input string t, input bit typed,
                         input int unsigned yr, mo, dy, hh, mi, ss, wd,
                         input status_e st);
    dir_row_t r;
    r.text           = t;
    r.typed          = typed;
    r.want.d.year    = 14'(yr);
    r.want.d.month   = 4'(mo);
    r.want.d.day     = 5'(dy);
    r.want.d.hour    = 5'(hh);
    r.want.d.minute  = 6'(mi);
    r.want.d.second  = 6'(ss);
    r.want.d.weekday = 3'(wd);
    r.want.st        = st;
    dir_rows.push_back(r);
  endtask

  // one character transfer, with random idle cycles ahead of it
  task automatic offer_char(input byte unsigned c, input bit eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_in_i     <= c;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // sends text_q with end_of_text on its last character and books the result
  task automatic send_text(input bit typed, input shifted_date_t want);
    shifted_date_t got;
    for (int i = 0; i < text_q.size(); i++) begin
      offer_char(text_q[i], i == text_q.size() - 1);
      parse_char(text_q[i]);
    end
    got = close_header();
    shifted_q.push_back(typed ? want : got);
    sent_chars += text_q.size();
  endtask

  // mostly well-formed headers biased toward month ends and late hours,
  // the rest junk names, oversized numbers, damaged text and raw noise
  task automatic build_random_header();
    int unsigned yr, mo, dy, hh, mi, ss, pos;
    text_q.delete();
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(255)));
      return;
    end
    case ($urandom_range(7))
      0:       yr = 1900;
      1:       yr = 2000;
      2:       yr = 2100;
      3:       yr = YearMax;
      4:       yr = $urandom_range(99);
      default: yr = $urandom_range(1970, 2099);
    endcase
    mo = $urandom_range(1, 12);
    case ($urandom_range(3))
      0, 1:    dy = month_days(yr, mo);
      default: dy = $urandom_range(1, 31);
    endcase
    hh = $urandom_range(1) ? $urandom_range(12, 23) : $urandom_range(0, 23);
    mi = $urandom_range(59);
    ss = $urandom_range(60);
    if ($urandom_range(15) == 0) begin
      case ($urandom_range(4))
        0:       dy = $urandom_range(99999);
        1:       yr = $urandom_range(99999);
        2:       hh = $urandom_range(99999);
        3:       mi = $urandom_range(99999);
        default: ss = $urandom_range(99999);
      endcase
    end
    if ($urandom_range(9) != 0) put_str(wday_tab[$urandom_range(6)]);
    else repeat ($urandom_range(5)) text_q.push_back(8'($urandom_range(33, 126)));
    put_str($urandom_range(7) == 0 ? ",  " : ", ");
    put_str($urandom_range(1) ? $sformatf("%02d ", dy) : $sformatf("%0d ", dy));
    if ($urandom_range(9) != 0) put_str(month_tab[mo - 1]);
    else repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(65, 122)));
    put_str($sformatf(" %04d %02d:%02d:%02d", yr, hh, mi, ss));
    if ($urandom_range(1)) put_str(" GMT");
    if ($urandom_range(7) == 0) begin
      pos = $urandom_range(text_q.size() - 1);
      case ($urandom_range(2))
        0:       text_q[pos] = 8'($urandom_range(255));
        1:       text_q = text_q[0:pos];
        default: if (text_q.size() > 1) text_q.delete(pos);
      endcase
    end
  endtask

  task automatic write_offset(input logic [4:0] v);
    in_valid_i <= 1'b0;
    while (shifted_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    offset_hours_we_i <= 1'b1;
    offset_hours_i    <= v;
    @(posedge clk_i);
    offset_hours_we_i <= 1'b0;
    tz_offset = v;
  endtask

  task automatic report_mismatch(input string msg);
    if (err_count < 100) $display("ERROR %0t: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------- receiver side

  always @(posedge clk_i) begin
    out_stall_i <= holdoff || ($urandom_range(99) < stall_pct);
  end

  // one long hold-off while the sender keeps offering, so the block backs up
  initial begin : long_holdoff
    wait (holdoff_go);
    @(posedge clk_i);
    holdoff <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    holdoff <= 1'b0;
  end

  always @(posedge clk_i) begin : result_check
    shifted_date_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (shifted_q.size() == 0) begin
        report_mismatch($sformatf("result transfer with none expected (year %0d)", year_out_o));
      end else begin
        want = shifted_q.pop_front();
        if (year_out_o != want.d.year)
          report_mismatch($sformatf("year %0d, want %0d", year_out_o, want.d.year));
        if (month_out_o != want.d.month)
          report_mismatch($sformatf("month %0d, want %0d", month_out_o, want.d.month));
        if (day_out_o != want.d.day)
          report_mismatch($sformatf("day %0d, want %0d", day_out_o, want.d.day));
        if (hour_out_o != want.d.hour)
          report_mismatch($sformatf("hour %0d, want %0d", hour_out_o, want.d.hour));
        if (minute_out_o != want.d.minute)
          report_mismatch($sformatf("minute %0d, want %0d", minute_out_o, want.d.minute));
        if (second_out_o != want.d.second)
          report_mismatch($sformatf("second %0d, want %0d", second_out_o, want.d.second));
        if (weekday_out_o != want.d.weekday)
          report_mismatch($sformatf("weekday %0d, want %0d", weekday_out_o, want.d.weekday));
        if (status_o != want.st)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.st));
      end
    end
  end

  // watchdog: consecutive cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QuietLimit) begin
      $display("http_date_parse_tz_shift verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : stimulus
    logic [4:0] off;
    tz_offset = OffsetReset;
    reset_parser();

    // typed rows assume the reset offset of 8 hours
    add_row("Sun, 16 Oct 2022 14:12:06 GMT", 1, 2022, 10, 16, 22, 12, 6, 7, ST_OK);
    add_row("Sat, 31 Dec 9999 23:59:60 GMT", 1, 9999, 1, 1, 7, 59, 60, 7, ST_OK);
    add_row("Fri, 00 Jan 0000 00:00:00", 1, 0, 1, 0, 8, 0, 0, 5, ST_OK);
    add_row("Xyz, 01 Foo 2020 10:00:00", 1, 2020, 0, 1, 18, 0, 0, 0, ST_BAD_WDAY);
    add_row("Mon, 01 Foo 2020 10:00:00", 1, 2020, 0, 1, 18, 0, 0, 1, ST_BAD_MONTH);
    add_row("Sun, 1 Jan 2020 10::05", 1, 2020, 1, 1, 18, 0, 5, 7, ST_MALFORMED);
    add_row("Sun, 1 Jan", 1, 0, 0, 1, 8, 0, 0, 7, ST_MALFORMED);
    add_row(",", 1, 0, 0, 0, 8, 0, 0, 0, ST_BAD_WDAY);
    // leap years, month ends, unknown month rollover, oversized numbers, bad names, stray text, extra spaces
    add_row("Mon, 28 Feb 2000 16:00:00", 0, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row("Tue, 28 Feb 1900 20:30:45", 0, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row("Thu, 30 Sep 2021 22:00:00", 0, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row("mon, 31 Qqq 2020 20:00:00", 0, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row("Wednesday, 5 Jan 2020 1:2:3", 0, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row("Sun, 99999 Jan 99999 99:99:99", 0, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row("Sun, 1x Jan 2020 10:00:00", 0, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row("Sun, 1   Jan    2020 23:00:00", 0, 0, 0, 0, 0, 0, 0, 0, ST_OK);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) begin
      text_q.delete();
      put_str(dir_rows[k].text);
      send_text(dir_rows[k].typed, dir_rows[k].want);
    end

    // random phases: a new offset each, idling mode cycling through the four patterns
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       off = 5'd0;
        1:       off = OffsetMax;
        2:       off = 5'd31;
        3:       off = 5'd16;
        4:       off = 5'd1;
        5:       off = 5'($urandom_range(24, 31));
        default: off = 5'($urandom_range(0, 23));
      endcase
      write_offset(off);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 81;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 81;
        end
        default: begin
          send_idle_pct = 16;
          stall_pct     = 16;
        end
      endcase
      if (p == 0) holdoff_go = 1'b1;
      sent_chars = 0;
      while (sent_chars < PhaseChars) begin
        build_random_header();
        send_text(1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (shifted_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0)
      $display("http_date_parse_tz_shift verification clean");
    else
      $display("http_date_parse_tz_shift verification failed");
    $finish;
  end

endmodule
